// ===== hdl/ggum_pkg.sv =====
// Shared types, constants and helpers for the GGUM probability/slope pipeline.
// Used by every module under hdl/.
package ggum_pkg;

    localparam int FRAC_BITS_DEF = 12;

    // Exponent width covers alpha(15b) times a 19b signed trait term.
    localparam int EXP_W   = 35;
    localparam int K_W     = 6;
    localparam int RED_W   = 36;
    localparam int LANES   = 4;
    localparam int TERMS   = 14;
    localparam int R_W     = 25;

    localparam logic [29:0]      LN2_Q30   = 30'd744261118;
    localparam logic [RED_W-1:0] EXP_LIMIT = 36'd42949672960;  // 40 in Q30
    localparam logic [30:0]      ONE_Q30   = 31'h40000000;

    // Divider sizing covers FRAC_BITS up to 20.
    localparam int QUO_W     = 25;
    localparam int DIV_NW    = 63;
    localparam int DIV_DW    = 55;
    localparam int DIV_CW    = DIV_DW + QUO_W;
    localparam int DIV_LANES = 3;

    localparam logic [1:0] REG_DISCRIM   = 2'd0;
    localparam logic [1:0] REG_LOCATION  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    typedef struct packed {
        logic             zero;
        logic [K_W-1:0]   k;
        logic [RED_W-1:0] rem;
    } red_lane_t;

    typedef struct packed {
        logic               zero;
        logic [K_W-1:0]     k;
        logic [29:0]        u;
        logic [30:0]        term;
        logic signed [31:0] sum;
    } exp_lane_t;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [DIV_NW-1:0] rem;
        logic [DIV_DW-1:0] den;
        logic [QUO_W-1:0]  q;
    } div_lane_t;

    // Q24 product of a signed and an unsigned value, truncated toward zero.
    function automatic logic signed [31:0] mul_q24s(input logic signed [31:0] a,
                                                    input logic [26:0] b);
        logic [31:0] mag;
        logic [58:0] prod;
        logic [31:0] m;
        mag  = a[31] ? 32'(-a) : 32'(a);
        prod = 59'(mag) * 59'(b);
        m    = prod[55:24];
        return a[31] ? $signed(-m) : $signed(m);
    endfunction

    // Signed Q8.16 clamp of a rounded quotient magnitude.
    function automatic logic signed [24:0] sat_slope(input logic neg, input logic ovf,
                                                     input logic [QUO_W-1:0] q);
        logic big;
        big = ovf | q[QUO_W-1];
        if (neg)
            return big ? 25'h1000000 : $signed(-q);
        else
            return big ? 25'h0FFFFFF : $signed(q);
    endfunction

endpackage

// ===== hdl/ggum_red_cell.sv =====
// One range-reduction cell: resolves one bit of k = floor(y / ln2) for all lanes.
// Depends on ggum_pkg.
module ggum_red_cell
    import ggum_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       vin,
    input  red_lane_t [LANES-1:0]      lin,
    output logic                       vout,
    output red_lane_t [LANES-1:0]      lout
);

    localparam logic [RED_W-1:0] STEP = RED_W'(LN2_Q30) << SHIFT;

    logic                  v_reg;
    red_lane_t [LANES-1:0] l_reg;
    red_lane_t [LANES-1:0] l_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            l_next[i] = lin[i];
            if (lin[i].rem >= STEP)
            begin
                l_next[i].rem      = lin[i].rem - STEP;
                l_next[i].k[SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            l_reg <= l_next;
    end

    assign vout = v_reg;
    assign lout = l_reg;

endmodule

// ===== hdl/ggum_exp_cell.sv =====
// One Taylor-series cell of exp(-u): term <- floor(term*u/2^30)/TERM, sum +/- term.
// Two register stages (product, then reciprocal divide). Depends on ggum_pkg.
module ggum_exp_cell
    import ggum_pkg::*;
#(
    parameter int TERM = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       vin,
    input  exp_lane_t [LANES-1:0]      lin,
    output logic                       vout,
    output exp_lane_t [LANES-1:0]      lout
);

    // Exact for dividends below 2^30: m = ceil(2^(30+L)/TERM).
    localparam int          LOG_T = $clog2(TERM);
    localparam int          SH    = 30 + LOG_T;
    localparam logic [31:0] RECIP = 32'(((64'd1 << SH) + 64'(TERM) - 64'd1) / 64'(TERM));
    localparam bit          SUB   = (TERM % 2) == 1;

    logic                  vm_reg, vo_reg;
    exp_lane_t [LANES-1:0] m_reg, m_next;
    exp_lane_t [LANES-1:0] o_reg, o_next;

    always_comb
    begin
        logic [60:0] prod;
        for (int i = 0; i < LANES; i++)
        begin
            m_next[i]      = lin[i];
            prod           = 61'(lin[i].term) * 61'(lin[i].u);
            m_next[i].term = prod[60:30];
        end
    end

    always_comb
    begin
        logic [61:0] qp;
        logic [30:0] t;
        for (int i = 0; i < LANES; i++)
        begin
            o_next[i]      = m_reg[i];
            qp             = 62'(m_reg[i].term[29:0]) * 62'(RECIP);
            t              = 31'(qp >> SH);
            o_next[i].term = t;
            if (SUB)
                o_next[i].sum = m_reg[i].sum - $signed(32'(t));
            else
                o_next[i].sum = m_reg[i].sum + $signed(32'(t));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= vin;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
            o_reg <= o_next;
        end
    end

    assign vout = vo_reg;
    assign lout = o_reg;

endmodule

// ===== hdl/ggum_div_cell.sv =====
// One restoring-division cell: resolves quotient bit BIT for all three dividers.
// Depends on ggum_pkg.
module ggum_div_cell
    import ggum_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         vin,
    input  div_lane_t [DIV_LANES-1:0]    lin,
    output logic                         vout,
    output div_lane_t [DIV_LANES-1:0]    lout
);

    logic                      v_reg;
    div_lane_t [DIV_LANES-1:0] l_reg, l_next;

    always_comb
    begin
        logic [DIV_CW-1:0] cmp;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            l_next[i] = lin[i];
            cmp       = DIV_CW'(lin[i].den) << BIT;
            if (DIV_CW'(lin[i].rem) >= cmp)
            begin
                l_next[i].rem    = lin[i].rem - cmp[DIV_NW-1:0];
                l_next[i].q[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            l_reg <= l_next;
    end

    assign vout = v_reg;
    assign lout = l_reg;

endmodule

// ===== hdl/ggum_probability_derivatives.sv =====
// Top level: GGUM response probability and trait slopes, fixed point.
// Depends on ggum_pkg, ggum_red_cell, ggum_exp_cell, ggum_div_cell.

// Fully pipelined: one trait value is taken every clock while the output is not
// stalled, and its result passes through 3 exponent/max stages, 6 ln2
// range-reduction cells, 14 two-stage Taylor cells, 6 ratio/product stages, a
// divider setup stage, 25 quotient-bit cells for the three rounded divisions,
// and the output register. The whole pipeline holds while a result sits
// unaccepted at the output; in_stall follows that.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; write them only
// while no beats are in flight.
module ggum_probability_derivatives
    import ggum_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] trait_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        prob_disagree,
    output logic [15:0]        prob_agree,
    output logic signed [24:0] first_slope,
    output logic signed [24:0] second_slope
);

    localparam int Q30_SH = 30 - 2 * FRAC_BITS;
    localparam int SHL    = (Q30_SH > 0) ? Q30_SH : 0;
    localparam int SHR    = (Q30_SH < 0) ? -Q30_SH : 0;
    localparam int YW     = EXP_W + 14;
    localparam int DEN2_SH = 2 * FRAC_BITS - 16;

    // configuration
    logic [14:0]        alpha_reg;
    logic signed [15:0] delta_reg, tau_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 15'd4096;
            delta_reg <= '0;
            tau_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DISCRIM:   alpha_reg <= cfg_data[14:0];
                REG_LOCATION:  delta_reg <= $signed(cfg_data);
                REG_THRESHOLD: tau_reg   <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    logic en;
    logic vo_reg;

    assign en       = !(vo_reg && out_stall);
    assign in_stall = !en;

    // ---- stage A: exponents
    logic signed [16:0]      d_c;
    logic signed [17:0]      e1_c;
    logic signed [18:0]      e2_c, e3_c;
    logic signed [EXP_W-1:0] al_c;
    logic signed [EXP_W-1:0] a_reg [3];
    logic                    va_reg;

    assign d_c  = 17'(trait_value) - 17'(delta_reg);
    assign e1_c = 18'(d_c) - 18'(tau_reg);
    assign e2_c = 19'(d_c) + 19'(d_c) - 19'(tau_reg);
    assign e3_c = 19'(d_c) + 19'(d_c) + 19'(d_c);
    assign al_c = EXP_W'($signed({1'b0, alpha_reg}));

    // ---- stage B: largest exponent
    logic signed [EXP_W-1:0] mx_c, mx_reg;
    logic signed [EXP_W-1:0] ab_reg [3];
    logic                    vb_reg;

    always_comb
    begin
        mx_c = '0;
        for (int i = 0; i < 3; i++)
            if (a_reg[i] > mx_c)
                mx_c = a_reg[i];
    end

    // ---- stage C: distances to the max in Q30
    red_lane_t [LANES-1:0] c_next, c_reg;
    logic                  vc_reg;

    always_comb
    begin
        logic [EXP_W-1:0] y;
        logic [YW-1:0]    yq;
        for (int i = 0; i < LANES; i++)
        begin
            y  = (i == 0) ? EXP_W'(mx_reg) : EXP_W'(mx_reg - ab_reg[(i + 2) % 3]);
            yq = (YW'(y) << SHL) >> SHR;
            c_next[i].zero = yq >= YW'(EXP_LIMIT);
            c_next[i].k    = '0;
            c_next[i].rem  = c_next[i].zero ? '0 : yq[RED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= al_c * EXP_W'(e1_c);
            a_reg[1] <= al_c * EXP_W'(e2_c);
            a_reg[2] <= al_c * EXP_W'(e3_c);
            mx_reg   <= mx_c;
            ab_reg   <= a_reg;
            c_reg    <= c_next;
        end
    end

    // ---- range reduction: k and u = y - k*ln2
    logic                  red_v [K_W+1];
    red_lane_t [LANES-1:0] red_l [K_W+1];

    assign red_v[0] = vc_reg;
    assign red_l[0] = c_reg;

    for (genvar g = 0; g < K_W; g++)
    begin : g_red
        ggum_red_cell #(.SHIFT(K_W - 1 - g)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (red_v[g]),
            .lin  (red_l[g]),
            .vout (red_v[g+1]),
            .lout (red_l[g+1])
        );
    end

    // ---- Taylor series chain
    logic                  exp_v [TERMS+1];
    exp_lane_t [LANES-1:0] exp_l [TERMS+1];

    assign exp_v[0] = red_v[K_W];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            exp_l[0][i].zero = red_l[K_W][i].zero;
            exp_l[0][i].k    = red_l[K_W][i].k;
            exp_l[0][i].u    = red_l[K_W][i].rem[29:0];
            exp_l[0][i].term = ONE_Q30;
            exp_l[0][i].sum  = $signed(32'(ONE_Q30));
        end
    end

    for (genvar g = 0; g < TERMS; g++)
    begin : g_exp
        ggum_exp_cell #(.TERM(g + 1)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (exp_v[g]),
            .lin  (exp_l[g]),
            .vout (exp_v[g+1]),
            .lout (exp_l[g+1])
        );
    end

    // ---- stage E: ratios in Q24
    logic [R_W-1:0] r_next [LANES];
    logic [R_W-1:0] r_reg  [LANES];

    always_comb
    begin
        logic [31:0] sp;
        logic [25:0] rnd;
        for (int i = 0; i < LANES; i++)
        begin
            sp  = exp_l[TERMS][i].sum[31] ? 32'd0 : 32'(exp_l[TERMS][i].sum);
            rnd = 26'((sp + 32'd32) >> 6);
            rnd = rnd >> exp_l[TERMS][i].k;
            r_next[i] = exp_l[TERMS][i].zero ? '0 : rnd[R_W-1:0];
        end
    end

    // ---- stages F..J: sums, products, numerators
    logic [26:0]        s_f_reg, tt_f_reg;
    logic [25:0]        n0_f_reg;
    logic [24:0]        p_reg [4];
    logic [49:0]        p10_c, p13_c, p20_c, p23_c;

    assign p10_c = 50'(r_reg[1]) * 50'(r_reg[0]);
    assign p13_c = 50'(r_reg[1]) * 50'(r_reg[3]);
    assign p20_c = 50'(r_reg[2]) * 50'(r_reg[0]);
    assign p23_c = 50'(r_reg[2]) * 50'(r_reg[3]);

    logic signed [27:0] bb_c, bb_reg;
    logic signed [28:0] aa_c, aa_reg;
    logic [53:0]        ss_c;
    logic [28:0]        s2_g_reg;
    logic [26:0]        s_g_reg, tt_g_reg;
    logic [25:0]        n0_g_reg;

    assign bb_c = 28'(p_reg[0]) - 28'({p_reg[1], 1'b0}) + 28'({p_reg[2], 1'b0})
                - 28'(p_reg[3]);
    assign aa_c = 29'(p_reg[0]) - 29'({p_reg[1], 3'b0}) + 29'({p_reg[2], 2'b0})
                - 29'({p_reg[3], 2'b0}) - 29'(p_reg[3]);
    assign ss_c = 54'(s_f_reg) * 54'(s_f_reg);

    logic [55:0]        s3_c;
    logic [30:0]        s3_h_reg;
    logic signed [31:0] as_reg, bt_reg;
    logic signed [43:0] ab_h_reg;
    logic [29:0]        al2_h_reg;
    logic [28:0]        s2_h_reg;
    logic [26:0]        s_h_reg;
    logic [25:0]        n0_h_reg;

    assign s3_c = 56'(s2_g_reg) * 56'(s_g_reg);

    logic signed [32:0] num2_reg;
    logic signed [43:0] ab_i_reg;
    logic [29:0]        al2_i_reg;
    logic [30:0]        s3_i_reg;
    logic [28:0]        s2_i_reg;
    logic [26:0]        s_i_reg;
    logic [25:0]        n0_i_reg;

    logic signed [63:0] sn_reg;
    logic signed [43:0] ab_j_reg;
    logic [30:0]        s3_j_reg;
    logic [28:0]        s2_j_reg;
    logic [26:0]        s_j_reg;
    logic [25:0]        n0_j_reg;

    logic ve_reg, vf_reg, vg_reg, vh_reg, vi_reg, vj_reg, vk_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;

            s_f_reg   <= 27'(r_reg[0]) + 27'(r_reg[1]) + 27'(r_reg[2]) + 27'(r_reg[3]);
            n0_f_reg  <= 26'(r_reg[0]) + 26'(r_reg[3]);
            tt_f_reg  <= 27'(r_reg[1]) + 27'({r_reg[2], 1'b0}) + 27'({r_reg[3], 1'b0})
                       + 27'(r_reg[3]);
            p_reg[0]  <= p10_c[48:24];
            p_reg[1]  <= p13_c[48:24];
            p_reg[2]  <= p20_c[48:24];
            p_reg[3]  <= p23_c[48:24];

            bb_reg    <= bb_c;
            aa_reg    <= aa_c;
            s2_g_reg  <= ss_c[52:24];
            s_g_reg   <= s_f_reg;
            tt_g_reg  <= tt_f_reg;
            n0_g_reg  <= n0_f_reg;

            s3_h_reg  <= s3_c[54:24];
            as_reg    <= mul_q24s(32'(aa_reg), s_g_reg);
            bt_reg    <= mul_q24s(32'(bb_reg), tt_g_reg);
            ab_h_reg  <= 44'($signed({1'b0, alpha_reg})) * 44'(bb_reg);
            al2_h_reg <= 30'(alpha_reg) * 30'(alpha_reg);
            s2_h_reg  <= s2_g_reg;
            s_h_reg   <= s_g_reg;
            n0_h_reg  <= n0_g_reg;

            num2_reg  <= 33'(as_reg) - 33'(bt_reg) - 33'(bt_reg);
            ab_i_reg  <= ab_h_reg;
            al2_i_reg <= al2_h_reg;
            s3_i_reg  <= s3_h_reg;
            s2_i_reg  <= s2_h_reg;
            s_i_reg   <= s_h_reg;
            n0_i_reg  <= n0_h_reg;

            sn_reg    <= 64'($signed({1'b0, al2_i_reg})) * 64'(num2_reg);
            ab_j_reg  <= ab_i_reg;
            s3_j_reg  <= s3_i_reg;
            s2_j_reg  <= s2_i_reg;
            s_j_reg   <= s_i_reg;
            n0_j_reg  <= n0_i_reg;
        end
    end

    // ---- stage K: divider setup (magnitude + den/2, overflow check)
    div_lane_t [DIV_LANES-1:0] k_next, k_reg;

    always_comb
    begin
        logic [DIV_NW-1:0] mag [DIV_LANES];
        logic [63:0]       sabs;
        logic [43:0]       aabs;
        aabs   = ab_j_reg[43] ? 44'(-ab_j_reg) : 44'(ab_j_reg);
        sabs   = sn_reg[63] ? 64'(-sn_reg) : 64'(sn_reg);
        mag[0] = DIV_NW'(n0_j_reg) << 16;
        mag[1] = DIV_NW'(aabs) << 16;
        mag[2] = sabs[DIV_NW-1:0];
        k_next[0].neg = 1'b0;
        k_next[1].neg = ab_j_reg[43];
        k_next[2].neg = sn_reg[63];
        k_next[0].den = DIV_DW'(s_j_reg);
        k_next[1].den = DIV_DW'(s2_j_reg) << FRAC_BITS;
        k_next[2].den = DIV_DW'(s3_j_reg) << DEN2_SH;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            k_next[i].rem = mag[i] + DIV_NW'(k_next[i].den >> 1);
            k_next[i].q   = '0;
            k_next[i].ovf = DIV_CW'(k_next[i].rem) >= (DIV_CW'(k_next[i].den) << QUO_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            k_reg <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg <= exp_v[TERMS];
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
            vk_reg <= vj_reg;
        end
    end

    // ---- quotient chain
    logic                      div_v [QUO_W+1];
    div_lane_t [DIV_LANES-1:0] div_l [QUO_W+1];

    assign div_v[0] = vk_reg;
    assign div_l[0] = k_reg;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        ggum_div_cell #(.BIT(QUO_W - 1 - g)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (div_v[g]),
            .lin  (div_l[g]),
            .vout (div_v[g+1]),
            .lout (div_l[g+1])
        );
    end

    // ---- output register
    logic [16:0]        q0_c, agree_c;
    logic [15:0]        pd_reg, pa_reg;
    logic signed [24:0] f1_reg, f2_reg;

    assign q0_c    = div_l[QUO_W][0].q[16:0];
    assign agree_c = 17'h10000 - q0_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= div_v[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg <= q0_c[16] ? 16'hFFFF : q0_c[15:0];
            pa_reg <= agree_c[16] ? 16'hFFFF : agree_c[15:0];
            f1_reg <= sat_slope(div_l[QUO_W][1].neg, div_l[QUO_W][1].ovf,
                                div_l[QUO_W][1].q);
            f2_reg <= sat_slope(div_l[QUO_W][2].neg, div_l[QUO_W][2].ovf,
                                div_l[QUO_W][2].q);
        end
    end

    assign out_valid     = vo_reg;
    assign prob_disagree = pd_reg;
    assign prob_agree    = pa_reg;
    assign first_slope   = f1_reg;
    assign second_slope  = f2_reg;

endmodule
